// ===== src/mkd_pkg.sv =====
package mkd_pkg;

	localparam int unsigned KEYS = 16;
	localparam int unsigned CODE_W = 4;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned MAP_W = KEYS * CODE_W;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = MAP_W;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP = 1'd1;

	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd400;
	localparam logic [MAP_W-1:0] KEY_MAP_RESET = 64'hDE0F_C987_B654_A321;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef logic [KEYS-1:0] matrix_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [MAP_W-1:0] key_map_t;

	typedef struct packed {
		logic emit;
		logic found;
		code_t code;
	} sess_result_t;

	typedef struct packed {
		logic open;
		logic latched;
	} sess_status_t;

endpackage

// ===== src/mkd_if.sv =====
interface mkd_scan_if;
	import mkd_pkg::*;

	logic valid;
	logic ready;
	matrix_t pressed_matrix;

	modport source (output valid, output pressed_matrix, input ready);
	modport sink (input valid, input pressed_matrix, output ready);
endinterface

interface mkd_result_if;
	import mkd_pkg::*;

	logic valid;
	logic ready;
	logic key_found;
	code_t key_code;

	modport source (output valid, output key_found, output key_code, input ready);
	modport sink (input valid, input key_found, input key_code, output ready);
endinterface

// ===== src/mkd_cfg_regs.sv =====
module mkd_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mkd_pkg::CFG_DATA_W-1:0] cfg_data,
	output mkd_pkg::count_t debounce_passes,
	output mkd_pkg::key_map_t key_map
);
	import mkd_pkg::*;

	count_t debounce_q;
	key_map_t key_map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			key_map_q <= KEY_MAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[COUNT_W-1:0];
				REG_KEY_MAP: key_map_q <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign debounce_passes = debounce_q;
	assign key_map = key_map_q;
endmodule

// ===== src/mkd_key_sel.sv =====
module mkd_key_sel (
	input mkd_pkg::matrix_t matrix,
	input mkd_pkg::key_map_t key_map,
	output mkd_pkg::code_t code
);
	import mkd_pkg::*;

	logic [$clog2(KEYS)-1:0] idx;

	// The first key is searched column by column and, within a column, row by row.
	always_comb begin
		idx = '0;
		for (int c = 3; c >= 0; c--) begin
			for (int r = 3; r >= 0; r--) begin
				if (matrix[r*4+c]) begin
					idx = 4'(r*4+c);
				end
			end
		end
	end

	assign code = key_map[idx*CODE_W +: CODE_W];
endmodule

// ===== src/mkd_session.sv =====
module mkd_session (
	input logic clk,
	input logic arst_n,
	input logic step,
	input mkd_pkg::matrix_t matrix,
	input mkd_pkg::count_t debounce_passes,
	input mkd_pkg::code_t map_code,
	output mkd_pkg::sess_result_t result,
	output mkd_pkg::sess_status_t status
);
	import mkd_pkg::*;

	count_t pass_count_q;
	logic have_latched_q;
	code_t latched_code_q;
	logic any_key;
	logic latch_now;

	assign any_key = |matrix;
	assign latch_now = any_key && !have_latched_q && (pass_count_q > debounce_passes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q <= '0;
			have_latched_q <= 1'b0;
			latched_code_q <= '0;
		end else if (step) begin
			if (any_key) begin
				if (latch_now) begin
					have_latched_q <= 1'b1;
					latched_code_q <= map_code;
				end
				if (pass_count_q != COUNT_MAX) begin
					pass_count_q <= pass_count_q + 1'b1;
				end
			end else begin
				pass_count_q <= '0;
				have_latched_q <= 1'b0;
				latched_code_q <= '0;
			end
		end
	end

	assign result.emit = !any_key && (pass_count_q != '0);
	assign result.found = have_latched_q;
	assign result.code = have_latched_q ? latched_code_q : '0;

	assign status.open = pass_count_q != '0;
	assign status.latched = have_latched_q;
endmodule

// ===== src/matrix_keypad_debounce_decoder_unit.sv =====
// Debounced 4x4 keypad decoder. Each scan beat is one full pass over the keypad; the block
// takes one beat per clock cycle unless it refuses one, and reports a key once the release
// pass has gone through an input register and a result register. A new beat is refused only
// while a finished result waits in the result register and the beat in the input register
// would produce another. The user must write the debounce threshold and the key map through
// the configuration port only while no scan beat is in flight; the block does not enforce it.
module matrix_keypad_debounce_decoder_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mkd_pkg::CFG_DATA_W-1:0] cfg_data,
	mkd_scan_if.sink scan,
	mkd_result_if.source result
);
	import mkd_pkg::*;

	count_t debounce_passes;
	key_map_t key_map;
	code_t map_code;
	sess_result_t sess_res;
	sess_status_t sess_st;

	logic valid_s1;
	matrix_t matrix_s1;
	logic advance;
	logic load_out;
	logic out_valid_q;
	logic out_found_q;
	code_t out_code_q;

	assign advance = valid_s1 && (!sess_res.emit || !out_valid_q || result.ready);
	assign load_out = advance && sess_res.emit;
	assign scan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			matrix_s1 <= scan.pressed_matrix;
		end
	end

	mkd_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.debounce_passes(debounce_passes),
		.key_map(key_map)
	);

	mkd_key_sel u_sel (
		.matrix(matrix_s1),
		.key_map(key_map),
		.code(map_code)
	);

	mkd_session u_sess (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.matrix(matrix_s1),
		.debounce_passes(debounce_passes),
		.map_code(map_code),
		.result(sess_res),
		.status(sess_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_found_q <= sess_res.found;
			out_code_q <= sess_res.code;
		end
	end

	assign result.valid = out_valid_q;
	assign result.key_found = out_found_q;
	assign result.key_code = out_code_q;

	a_latched_in_session: assert property (@(posedge clk) disable iff (!arst_n)
		sess_st.latched |-> sess_st.open)
		else $error("key latched outside an open session");

	a_release_closes: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> !sess_st.open && out_valid_q)
		else $error("release beat did not close the session");

	a_no_key_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> out_code_q == '0)
		else $error("short press reported a nonzero code");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(matrix_s1))
		else $error("stalled scan beat lost");
endmodule
